// File: rtl/stm_pkg.sv
// Package: shared types, codes and fixed sizes for the synthesizer serial master.
`timescale 1ns / 1ps

package stm_pkg;

    // Frame geometry
    localparam int DATA_BITS     = 20;
    localparam int ADDR_RW_BITS  = 5;
    localparam int TICKS_PER_BIT = 4;
    localparam int PACKET_BITS   = ADDR_RW_BITS + DATA_BITS;

    localparam int TICK_W = $clog2(TICKS_PER_BIT);
    localparam int BIT_W  = $clog2(PACKET_BITS);

    // Field widths
    localparam int MODE_W   = 2;
    localparam int FREQ_W   = 13;
    localparam int RADDR_W  = 4;
    localparam int OFFSET_W = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = OFFSET_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNTH_ADDR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_OFFSET = 1'd1;

    localparam logic [RADDR_W-1:0]  SYNTH_ADDR_RESET  = 4'd1;
    localparam logic [OFFSET_W-1:0] FREQ_OFFSET_RESET = 10'd479;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TUNE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd3;

    // Read/write flag in the packet
    localparam logic RW_READ  = 1'b0;
    localparam logic RW_WRITE = 1'b1;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_LEAD  = 8'b0000_0010,
        PH_ADDR  = 8'b0000_0100,
        PH_READ  = 8'b0000_1000,
        PH_GAP   = 8'b0001_0000,
        PH_WLEAD = 8'b0010_0000,
        PH_WRITE = 8'b0100_0000,
        PH_TAIL  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [FREQ_W-1:0]      frequency_mhz;
        logic [RADDR_W-1:0]     reg_address;
        logic [PACKET_BITS-1:0] write_word;
        logic                   data_in;
    } stm_in_t;

    typedef struct packed {
        logic                 cs_n;
        logic                 sclk;
        logic                 mosi;
        logic                 mosi_drive;
        logic                 busy_res;
        logic                 done_res;
        logic [DATA_BITS-1:0] read_value;
        logic                 write_skipped;
        logic                 rejected;
    } stm_out_t;

    typedef struct packed {
        phase_t                 phase;
        logic [BIT_W-1:0]       bit_count;
        logic [TICK_W-1:0]      tick_count;
        logic [PACKET_BITS-1:0] shift_out;
        logic [DATA_BITS-1:0]   read_shift;
        logic [DATA_BITS-1:0]   pending_data;
        logic                   tune_active;
    } stm_state_t;

endpackage

// File: rtl/synth_tune_serial_master_unit.sv
// Top level: three-wire serial master for a receiver synthesizer, tick-driven.
`timescale 1ns / 1ps
// Pipeline: a tick transfer loads the input register; the result register then loads
//   the step result once it is empty or draining, and the result is offered from it.
// Throughput: one tick per cycle; the input side keeps taking transfers while the
//   result register holds a finished result, as long as that result drains.
// Reset: rst_n low clears the handshake, sets the frame to idle with counters and
//   shift registers at zero, and loads the register defaults (address 1, offset 479).

module synth_tune_serial_master_unit
    import stm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Tick/command channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  stm_in_t               in_data,

    // Line-level result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output stm_out_t              out_data,

    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                in_full_reg;
    stm_in_t             in_q_reg;
    logic                out_full_reg;
    stm_out_t            out_q_reg;

    stm_state_t          state_reg;
    stm_state_t          state_next;
    stm_out_t            step_res;

    logic [RADDR_W-1:0]  synth_addr_reg;
    logic [OFFSET_W-1:0] freq_offset_reg;

    logic                advance;
    logic                in_take;

    // A held tick advances when the result register is empty or its transfer
    // completes in this cycle.
    assign advance  = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_full_reg;
    assign out_data  = out_q_reg;

    // One tick of frame logic between the input register and the result register
    stm_step u_step (
        .cur         (state_reg),
        .item        (in_q_reg),
        .synth_addr  (synth_addr_reg),
        .freq_offset (freq_offset_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    // Handshake flags and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            state_reg    <= '{phase: PH_IDLE, default: '0};
        end else begin
            if (in_take) begin
                in_full_reg <= 1'b1;
            end else if (advance) begin
                in_full_reg <= 1'b0;
            end

            if (advance) begin
                out_full_reg <= 1'b1;
                state_reg    <= state_next;
            end else if (!out_stall) begin
                out_full_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold while stalled, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_q_reg <= in_data;
        end
        if (advance) begin
            out_q_reg <= step_res;
        end
    end

    // Configuration registers; write only while no transfer is in flight (the block does not enforce this)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            synth_addr_reg  <= SYNTH_ADDR_RESET;
            freq_offset_reg <= FREQ_OFFSET_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SYNTH_ADDR:  synth_addr_reg  <= cfg_data[RADDR_W-1:0];
                CFG_FREQ_OFFSET: freq_offset_reg <= cfg_data[OFFSET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: rtl/stm_step.sv
// Step logic: one quarter-bit tick of the serial master, state in, state and line levels out.
`timescale 1ns / 1ps

module stm_step
    import stm_pkg::*;
(
    input  stm_state_t            cur,
    input  stm_in_t               item,
    input  logic [RADDR_W-1:0]    synth_addr,
    input  logic [OFFSET_W-1:0]   freq_offset,
    output stm_state_t            nxt,
    output stm_out_t              res
);

    function automatic logic [PACKET_BITS-1:0] make_packet(
        input logic [RADDR_W-1:0]   addr,
        input logic                 rw,
        input logic [DATA_BITS-1:0] data
    );
        logic [PACKET_BITS-1:0] pkt;
        pkt = PACKET_BITS'(addr[ADDR_RW_BITS-2:0])
            | (PACKET_BITS'(rw) << (ADDR_RW_BITS - 1))
            | (PACKET_BITS'(data) << ADDR_RW_BITS);
        return pkt;
    endfunction

    stm_state_t          mid;
    logic [FREQ_W:0]     diff;
    logic [FREQ_W-2:0]   half;
    logic [DATA_BITS-1:0] tune_word;
    logic                hi;
    logic                tick_end;
    logic [TICK_W-1:0]   tick_inc;

    // Divider word: N = half/32 in bits 7 and up, A = half%32 in the low five bits
    assign diff      = {1'b0, item.frequency_mhz} - (FREQ_W + 1)'(freq_offset);
    assign half      = diff[FREQ_W-1:1];
    assign tune_word = DATA_BITS'({half[FREQ_W-2:5], 2'b00, half[4:0]});

    always_comb
    begin
        mid = cur;
        res = '0;
        res.cs_n = 1'b1;
        res.mosi_drive = 1'b1;

        // Command decode
        if (item.mode != MODE_TICK) begin
            if (cur.phase != PH_IDLE) begin
                res.rejected = 1'b1;
            end else begin
                unique case (item.mode)
                    MODE_TUNE:
                    begin
                        if (diff[FREQ_W]) begin
                            res.rejected = 1'b1;
                        end else begin
                            mid.pending_data = tune_word;
                            mid.shift_out    = make_packet(synth_addr, RW_READ, '0);
                            mid.read_shift   = '0;
                            mid.tune_active  = 1'b1;
                            mid.phase        = PH_LEAD;
                        end
                    end
                    MODE_READ:
                    begin
                        mid.shift_out   = make_packet(item.reg_address, RW_READ, '0);
                        mid.read_shift  = '0;
                        mid.tune_active = 1'b0;
                        mid.phase       = PH_LEAD;
                    end
                    MODE_WRITE:
                    begin
                        mid.shift_out   = item.write_word;
                        mid.tune_active = 1'b0;
                        mid.phase       = PH_WLEAD;
                    end
                    default:
                    begin
                    end
                endcase
                if (mid.phase != PH_IDLE) begin
                    mid.tick_count = '0;
                    mid.bit_count  = '0;
                end
            end
        end

        res.busy_res = (mid.phase != PH_IDLE);
        hi       = (mid.tick_count >= TICK_W'(TICKS_PER_BIT / 2));
        tick_end = (mid.tick_count == TICK_W'(TICKS_PER_BIT - 1));
        tick_inc = tick_end ? '0 : mid.tick_count + 1'b1;

        nxt = mid;
        unique case (mid.phase)
            PH_LEAD, PH_WLEAD:
            begin
                res.cs_n = 1'b0;
                nxt.tick_count = tick_inc;
                if (tick_end) begin
                    nxt.phase     = (mid.phase == PH_LEAD) ? PH_ADDR : PH_WRITE;
                    nxt.bit_count = '0;
                end
            end
            PH_ADDR, PH_WRITE:
            begin
                res.cs_n = 1'b0;
                res.sclk = hi;
                res.mosi = mid.shift_out[0];
                nxt.tick_count = tick_inc;
                if (tick_end) begin
                    // Advance to the next bit, LSB first
                    nxt.shift_out = mid.shift_out >> 1;
                    nxt.bit_count = mid.bit_count + 1'b1;
                    if (mid.phase == PH_ADDR
                        && mid.bit_count == BIT_W'(ADDR_RW_BITS - 1)) begin
                        nxt.phase     = PH_READ;
                        nxt.bit_count = '0;
                    end else if (mid.phase == PH_WRITE
                        && mid.bit_count == BIT_W'(PACKET_BITS - 1)) begin
                        nxt.phase     = PH_TAIL;
                        nxt.bit_count = '0;
                    end
                end
            end
            PH_READ:
            begin
                res.cs_n = 1'b0;
                res.mosi_drive = 1'b0;
                res.sclk = hi;
                if (mid.tick_count == TICK_W'(TICKS_PER_BIT / 4)) begin
                    nxt.read_shift[mid.bit_count] =
                        mid.read_shift[mid.bit_count] | item.data_in;
                end
                nxt.tick_count = tick_inc;
                if (tick_end) begin
                    nxt.bit_count = mid.bit_count + 1'b1;
                    if (mid.bit_count == BIT_W'(DATA_BITS - 1)) begin
                        nxt.bit_count = '0;
                        if (mid.tune_active && nxt.read_shift != mid.pending_data) begin
                            nxt.phase = PH_GAP;
                        end else begin
                            res.write_skipped = mid.tune_active;
                            res.done_res      = 1'b1;
                            nxt.tune_active   = 1'b0;
                            nxt.phase         = PH_IDLE;
                        end
                    end
                end
            end
            PH_GAP:
            begin
                nxt.shift_out  = make_packet(synth_addr, RW_WRITE, mid.pending_data);
                nxt.tick_count = '0;
                nxt.bit_count  = '0;
                nxt.phase      = PH_WLEAD;
            end
            PH_TAIL:
            begin
                res.cs_n = 1'b0;
                nxt.tick_count = tick_inc;
                if (tick_end) begin
                    res.done_res    = 1'b1;
                    nxt.tune_active = 1'b0;
                    nxt.phase       = PH_IDLE;
                end
            end
            PH_IDLE:
            begin
            end
            default:
            begin
                nxt.phase = PH_IDLE;
            end
        endcase

        res.read_value = nxt.read_shift;
    end

endmodule

// File: tb/sv/synth_tune_serial_master_unit_test.sv
// Testbench for the synthesizer serial master: line-level prediction per tick, checked per transfer.
`timescale 1ns / 1ps

module synth_tune_serial_master_unit_test;

    import stm_pkg::*;

    // Bench timing and run size
    localparam int CLK_HALF_NS   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int PIPE_LATENCY  = 2;
    localparam int RANDOM_ITEMS  = 400;
    localparam int RANDOM_PHASES = 5;
    localparam int MAX_REPORTS   = 50;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    // Frame geometry in ticks, counted from the command tick (tick 0)
    localparam int READ_FIRST  = TICKS_PER_BIT * (1 + ADDR_RW_BITS);
    localparam int READ_TICKS  = DATA_BITS * TICKS_PER_BIT;
    localparam int SAMPLE_TICK = TICKS_PER_BIT / 4;
    localparam int SKIP_LEN    = READ_FIRST + READ_TICKS;
    localparam int WRITE_LEN   = TICKS_PER_BIT * (PACKET_BITS + 2);
    localparam int TUNE_LEN    = SKIP_LEN + 1 + WRITE_LEN;

    // Divider word layout: swallow count A in the low bits, N above a two-bit hole
    localparam int SWALLOW_W = 5;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    stm_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    stm_out_t              out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    synth_tune_serial_master_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(CLK_HALF_NS) clk = 1'b1;
        #(CLK_HALF_NS) clk = 0;
    end

    // Ticks waiting to be offered, and line levels waiting to be seen
    stm_in_t  pending_items[$];
    stm_out_t expected_levels[$];
    int       items_queued = 0;
    int       mismatch_count = 0;

    // Shadow of the serial master: register copies and frame state
    logic [RADDR_W-1:0]     cfg_synth_addr = SYNTH_ADDR_RESET;
    logic [OFFSET_W-1:0]    cfg_offset = FREQ_OFFSET_RESET;
    phase_t                 frame_phase = PH_IDLE;
    int                     bit_idx = 0;
    int                     quarter = 0;
    logic [PACKET_BITS-1:0] tx_shift = '0;
    logic [DATA_BITS-1:0]   rx_shift = '0;
    logic [DATA_BITS-1:0]   target_word = '0;
    logic                   tuning = 1'b0;

    // Idle pattern state for each side
    int send_gap = 0;
    int send_run = 0;
    int stall_left = 0;
    int stall_run = 0;

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Mostly no gap, often a short one, now and then a long one; sometimes a
    // long stretch with no gaps at all.
    function automatic int pick_gap(inout int run_left);
        int r;
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            run_left = $urandom_range(30, 200);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // N = half / 32 goes in bit 7 and up, A = half % 32 in the low bits.
    function automatic logic [DATA_BITS-1:0] divider_word(logic [FREQ_W-1:0] f,
                                                          logic [OFFSET_W-1:0] off);
        logic [FREQ_W-1:0] half;
        half = (f - FREQ_W'(off)) >> 1;
        return DATA_BITS'({half[FREQ_W-1:SWALLOW_W], 2'b00, half[SWALLOW_W-1:0]});
    endfunction

    function automatic logic [PACKET_BITS-1:0] build_packet(logic [RADDR_W-1:0] addr,
                                                            logic rw,
                                                            logic [DATA_BITS-1:0] data);
        return {data, rw, addr};
    endfunction

    // Advance the quarter-bit counter; true when a bit period closes.
    function automatic bit quarter_step();
        quarter++;
        if (quarter >= TICKS_PER_BIT)
        begin
            quarter = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Run one tick through the shadow and return the line levels it should show.
    function automatic stm_out_t predict_line_levels(stm_in_t t);
        stm_out_t r;
        bit       started;
        logic     hi;
        r            = '0;
        r.cs_n       = 1'b1;
        r.mosi_drive = 1'b1;
        started      = 1'b0;
        if (t.mode != MODE_TICK)
        begin
            if (frame_phase != PH_IDLE)
                r.rejected = 1'b1;
            else if (t.mode == MODE_TUNE)
            begin
                if (t.frequency_mhz < cfg_offset)
                    r.rejected = 1'b1;
                else
                begin
                    target_word = divider_word(t.frequency_mhz, cfg_offset);
                    tx_shift    = build_packet(cfg_synth_addr, RW_READ, '0);
                    rx_shift    = '0;
                    tuning      = 1'b1;
                    frame_phase = PH_LEAD;
                    started     = 1'b1;
                end
            end
            else if (t.mode == MODE_READ)
            begin
                tx_shift    = build_packet(t.reg_address, RW_READ, '0);
                rx_shift    = '0;
                tuning      = 1'b0;
                frame_phase = PH_LEAD;
                started     = 1'b1;
            end
            else
            begin
                tx_shift    = t.write_word;
                tuning      = 1'b0;
                frame_phase = PH_WLEAD;
                started     = 1'b1;
            end
        end
        if (started)
        begin
            quarter = 0;
            bit_idx = 0;
        end

        r.busy_res = (frame_phase != PH_IDLE);
        hi         = (quarter >= TICKS_PER_BIT / 2);

        case (frame_phase)
            PH_LEAD, PH_WLEAD:
            begin
                r.cs_n = 1'b0;
                if (quarter_step())
                begin
                    frame_phase = (frame_phase == PH_LEAD) ? PH_ADDR : PH_WRITE;
                    bit_idx     = 0;
                end
            end
            PH_ADDR, PH_WRITE:
            begin
                r.cs_n = 1'b0;
                r.sclk = hi;
                r.mosi = tx_shift[bit_idx];
                if (quarter_step())
                begin
                    bit_idx++;
                    if (frame_phase == PH_ADDR && bit_idx >= ADDR_RW_BITS)
                    begin
                        frame_phase = PH_READ;
                        bit_idx     = 0;
                    end
                    else if (frame_phase == PH_WRITE && bit_idx >= PACKET_BITS)
                    begin
                        frame_phase = PH_TAIL;
                        bit_idx     = 0;
                    end
                end
            end
            PH_READ:
            begin
                r.cs_n       = 1'b0;
                r.mosi_drive = 1'b0;
                r.sclk       = hi;
                if (quarter == SAMPLE_TICK && bit_idx < DATA_BITS && t.data_in)
                    rx_shift[bit_idx] = 1'b1;
                if (quarter_step())
                begin
                    bit_idx++;
                    if (bit_idx >= DATA_BITS)
                    begin
                        bit_idx = 0;
                        if (tuning && rx_shift != target_word)
                            frame_phase = PH_GAP;
                        else
                        begin
                            r.write_skipped = tuning;
                            r.done_res      = 1'b1;
                            tuning          = 1'b0;
                            frame_phase     = PH_IDLE;
                        end
                    end
                end
            end
            PH_GAP:
            begin
                // The write picks up the register address in force right now.
                tx_shift    = build_packet(cfg_synth_addr, RW_WRITE, target_word);
                quarter     = 0;
                bit_idx     = 0;
                frame_phase = PH_WLEAD;
            end
            PH_TAIL:
            begin
                r.cs_n = 1'b0;
                if (quarter_step())
                begin
                    r.done_res  = 1'b1;
                    tuning      = 1'b0;
                    frame_phase = PH_IDLE;
                end
            end
            default:
                frame_phase = PH_IDLE;
        endcase

        r.read_value = rx_shift;
        return r;
    endfunction

    // Driver: offer the oldest pending tick, hold it while stalled, predict on transfer.
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit took;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                expected_levels.push_back(predict_line_levels(in_data));
                void'(pending_items.pop_front());
            end
            if (in_valid && !took)
            begin
                // stalled: keep valid and payload as they are
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_items[0];
                send_gap = pick_gap(send_run);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each result transfer against the oldest prediction, then
    // pick how long to stall before the next one.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        stm_out_t got;
        stm_out_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (expected_levels.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = expected_levels.pop_front();
                    if (got.cs_n !== want.cs_n)
                        report_mismatch($sformatf("cs_n got %0b want %0b",
                                                  got.cs_n, want.cs_n));
                    if (got.sclk !== want.sclk)
                        report_mismatch($sformatf("sclk got %0b want %0b",
                                                  got.sclk, want.sclk));
                    if (got.mosi !== want.mosi)
                        report_mismatch($sformatf("mosi got %0b want %0b",
                                                  got.mosi, want.mosi));
                    if (got.mosi_drive !== want.mosi_drive)
                        report_mismatch($sformatf("mosi_drive got %0b want %0b",
                                                  got.mosi_drive, want.mosi_drive));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy_res got %0b want %0b",
                                                  got.busy_res, want.busy_res));
                    if (got.done_res !== want.done_res)
                        report_mismatch($sformatf("done_res got %0b want %0b",
                                                  got.done_res, want.done_res));
                    if (got.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value got %05h want %05h",
                                                  got.read_value, want.read_value));
                    if (got.write_skipped !== want.write_skipped)
                        report_mismatch($sformatf("write_skipped got %0b want %0b",
                                                  got.write_skipped, want.write_skipped));
                    if (got.rejected !== want.rejected)
                        report_mismatch($sformatf("rejected got %0b want %0b",
                                                  got.rejected, want.rejected));
                end
                stall_left = pick_gap(stall_run);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // A tick with every field random; only the mode is fixed.
    function automatic stm_in_t rand_item(logic [MODE_W-1:0] m);
        stm_in_t it;
        it.mode          = m;
        it.frequency_mhz = FREQ_W'($urandom);
        it.reg_address   = RADDR_W'($urandom);
        it.write_word    = PACKET_BITS'($urandom);
        it.data_in       = 1'($urandom);
        return it;
    endfunction

    // Queue plain ticks at frame positions first_k onward. On the sampling tick
    // of each read bit, drive the matching bit of readback; now and then swap a
    // tick for a command that must be turned away.
    task automatic add_ticks(int n, int first_k, logic [DATA_BITS-1:0] readback,
                             int inject_pct);
        stm_in_t it;
        int      k;
        for (int j = 0; j < n; j++)
        begin
            k  = first_k + j;
            it = rand_item(MODE_TICK);
            if (k >= READ_FIRST && k < SKIP_LEN &&
                (k - READ_FIRST) % TICKS_PER_BIT == SAMPLE_TICK)
                it.data_in = readback[(k - READ_FIRST) / TICKS_PER_BIT];
            if ($urandom_range(0, 99) < inject_pct)
                it.mode = MODE_W'($urandom_range(1, 3));
            pending_items.push_back(it);
        end
        items_queued += n;
    endtask

    task automatic add_frame(stm_in_t cmd, int len, logic [DATA_BITS-1:0] readback,
                             int inject_pct);
        pending_items.push_back(cmd);
        items_queued++;
        add_ticks(len - 1, 1, readback, inject_pct);
    endtask

    // Tune: when same is set, the register reads back the new word, so the
    // write is skipped; otherwise it reads back something else.
    task automatic add_tune(logic [FREQ_W-1:0] f, bit same, int inject_pct);
        stm_in_t              cmd;
        logic [DATA_BITS-1:0] word;
        logic [DATA_BITS-1:0] readback;
        cmd               = rand_item(MODE_TUNE);
        cmd.frequency_mhz = f;
        if (f < cfg_offset)
        begin
            pending_items.push_back(cmd);
            items_queued++;
        end
        else
        begin
            word = divider_word(f, cfg_offset);
            if (same)
                readback = word;
            else if ($urandom_range(0, 1))
                readback = word ^ (DATA_BITS'(1) << $urandom_range(0, DATA_BITS - 1));
            else
                readback = DATA_BITS'($urandom);
            add_frame(cmd, same ? SKIP_LEN : TUNE_LEN, readback, inject_pct);
        end
    endtask

    task automatic add_read(logic [RADDR_W-1:0] addr, logic [DATA_BITS-1:0] readback,
                            int inject_pct);
        stm_in_t cmd;
        cmd             = rand_item(MODE_READ);
        cmd.reg_address = addr;
        add_frame(cmd, SKIP_LEN, readback, inject_pct);
    endtask

    task automatic add_write(logic [PACKET_BITS-1:0] word, int inject_pct);
        stm_in_t cmd;
        cmd            = rand_item(MODE_WRITE);
        cmd.write_word = word;
        add_frame(cmd, WRITE_LEN, DATA_BITS'($urandom), inject_pct);
    endtask

    function automatic logic [FREQ_W-1:0] rand_tune_freq();
        return FREQ_W'(cfg_offset + $urandom_range(0, (1 << FREQ_W) - 1 - cfg_offset));
    endfunction

    // One random sequence: mostly complete frames, some refused tunes, some noise.
    task automatic add_random_frame();
        int r;
        int pct;
        int n;
        r   = $urandom_range(0, 99);
        pct = ($urandom_range(0, 3) == 0) ? 3 : 0;
        if (r < 10 && cfg_offset != 0)
            add_tune(FREQ_W'($urandom_range(0, cfg_offset - 1)), 1'b0, 0);
        else if (r < 30)
            add_tune(rand_tune_freq(), 1'b1, pct);
        else if (r < 50)
            add_tune(rand_tune_freq(), 1'b0, pct);
        else if (r < 70)
            add_read(RADDR_W'($urandom), DATA_BITS'($urandom), pct);
        else if (r < 88)
            add_write(PACKET_BITS'($urandom), pct);
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n)
                pending_items.push_back(rand_item(MODE_W'($urandom_range(0, 3))));
            items_queued += n;
            // let any frame the burst started run out
            add_ticks(TUNE_LEN, TUNE_LEN, '0, 0);
        end
        add_ticks($urandom_range(0, 3), TUNE_LEN, '0, 0);
    endtask

    // Hold until every queued tick has gone and every result has come back.
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_levels.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // Register write; only called with nothing in flight, so the shadow copy
    // can follow at once.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_SYNTH_ADDR)
            cfg_synth_addr = value[RADDR_W-1:0];
        else
            cfg_offset = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        stm_in_t              it;
        logic [DATA_BITS-1:0] readback;
        int                   phase_goal;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle ticks with all fields low, then all high.
        it = '0;
        pending_items.push_back(it);
        it      = '1;
        it.mode = MODE_TICK;
        pending_items.push_back(it);
        items_queued += 2;

        // Reset registers in force: mismatching tune, skipped tune.
        add_tune(13'd5800, 1'b0, 0);
        add_tune(13'd5800, 1'b1, 0);

        // One below the offset is refused; exactly at it gives word zero.
        add_tune(FREQ_W'(FREQ_OFFSET_RESET) - 1'b1, 1'b0, 0);
        add_tune(FREQ_W'(FREQ_OFFSET_RESET), 1'b1, 0);

        // Reads at both address extremes; commands thrown in while busy,
        // one of them on the very last tick of the frame.
        add_read('1, '1, 10);
        pending_items[pending_items.size() - 1].mode = MODE_WRITE;
        add_read('0, '0, 0);

        // Raw writes of all ones and all zeros.
        add_write('1, 0);
        add_write('0, 0);

        // Tune at the top frequency, reading back the complement. Drain at the
        // end of the read phase and move the register address before the
        // write part begins.
        it               = rand_item(MODE_TUNE);
        it.frequency_mhz = '1;
        readback         = ~divider_word(it.frequency_mhz, cfg_offset);
        add_frame(it, SKIP_LEN, readback, 0);
        wait_drained();
        write_reg(CFG_SYNTH_ADDR, CFG_DATA_W'(6));
        add_ticks(TUNE_LEN - SKIP_LEN + 2, SKIP_LEN, readback, 0);
        wait_drained();

        // Low extremes of both registers.
        write_reg(CFG_SYNTH_ADDR, '0);
        write_reg(CFG_FREQ_OFFSET, '0);
        add_tune('0, 1'b0, 0);
        wait_drained();

        // High extremes; upper data bits set on the address write are dropped.
        write_reg(CFG_SYNTH_ADDR, '1);
        write_reg(CFG_FREQ_OFFSET, '1);
        add_tune(13'd1022, 1'b0, 0);
        add_tune('1, 1'b0, 0);
        wait_drained();

        // Random phases: keep the high extremes, then the low ones, then
        // random settings. Drain now and then mid-phase as well.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 1)
            begin
                write_reg(CFG_SYNTH_ADDR, '0);
                write_reg(CFG_FREQ_OFFSET, '0);
            end
            else if (p > 1)
            begin
                write_reg(CFG_SYNTH_ADDR, CFG_DATA_W'($urandom));
                write_reg(CFG_FREQ_OFFSET, CFG_DATA_W'($urandom));
            end
            phase_goal = items_queued + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_queued < phase_goal)
            begin
                add_random_frame();
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (PIPE_LATENCY + 6) @(posedge clk);
        if (expected_levels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Drop the run if it hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
